// ----- hw/rtl/rnarq_pkg.sv -----
// Shared types and constants for the stop-and-wait radio link engine.
// Holds the transaction payload structs, configuration and state records.
// No dependencies.
package rnarq_pkg;

    // Register indexes on the configuration write channel
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_NODE_ADDRESS    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GATEWAY_ADDRESS = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_WAKE_INTERVAL   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT_MS  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SLEEP_PERIOD    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_POLLED_MODE     = 3'd6;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_NODE_ADDRESS    = 8'd1;
    localparam logic [7:0]  RST_GATEWAY_ADDRESS = 8'd0;
    localparam logic [15:0] RST_WAKE_INTERVAL   = 16'd1;
    localparam logic [7:0]  RST_RETRY_LIMIT     = 8'd3;
    localparam logic [15:0] RST_ACK_TIMEOUT_MS  = 16'd100;
    localparam logic [15:0] RST_SLEEP_PERIOD    = 16'd1000;
    localparam logic        RST_POLLED_MODE     = 1'b0;

    localparam int unsigned CfgDataW = 16;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SLEEP   = 3'd1,
        PH_SENDING = 3'd2,
        PH_WAIT    = 3'd3,
        PH_LISTEN  = 3'd4
    } rnarq_phase_t;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [7:0]  gateway_address;
        logic [15:0] wake_interval;
        logic [7:0]  retry_limit;
        logic [15:0] ack_timeout_ms;
        logic [15:0] sleep_period;
        logic        polled_mode;
    } rnarq_cfg_t;

    typedef struct packed {
        logic        func;
        logic        rx_valid;
        logic [7:0]  rx_dest;
        logic        rx_ack_req;
        logic        rx_admin;
        logic [7:0]  rx_mid;
        logic        link_free;
        logic [31:0] now_ms;
        logic [7:0]  fresh_mid;
    } rnarq_in_t;

    typedef struct packed {
        logic        send_banner;
        logic [7:0]  banner_ack_id;
        logic        send_data;
        logic [7:0]  data_mid;
        logic        data_ack_req;
        logic [15:0] sleep_for;
        logic        radio_wake;
        logic        led_awake;
        logic        led_test;
        logic        deliver_rx;
        logic [2:0]  link_state;
    } rnarq_out_t;

    typedef struct packed {
        rnarq_phase_t phase;
        logic [15:0]  wake_countdown;
        logic [7:0]   attempts_left;
        logic [31:0]  ack_deadline;
        logic [7:0]   pending_ack_id;
        logic [7:0]   outgoing_mid;
        logic         outgoing_ack_req;
        logic         awake_led;
        logic         test_led;
    } rnarq_state_t;

endpackage

// ----- hw/rtl/rnarq_cfg_regs.sv -----
// Configuration register file of the radio link engine.
// Decodes write transactions by register index; uses rnarq_pkg.
module rnarq_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [rnarq_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rnarq_pkg::CfgDataW-1:0] cfg_data,
    output rnarq_pkg::rnarq_cfg_t        cfg
);

    rnarq_pkg::rnarq_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_address    <= rnarq_pkg::RST_NODE_ADDRESS;
            cfg_reg.gateway_address <= rnarq_pkg::RST_GATEWAY_ADDRESS;
            cfg_reg.wake_interval   <= rnarq_pkg::RST_WAKE_INTERVAL;
            cfg_reg.retry_limit     <= rnarq_pkg::RST_RETRY_LIMIT;
            cfg_reg.ack_timeout_ms  <= rnarq_pkg::RST_ACK_TIMEOUT_MS;
            cfg_reg.sleep_period    <= rnarq_pkg::RST_SLEEP_PERIOD;
            cfg_reg.polled_mode     <= rnarq_pkg::RST_POLLED_MODE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rnarq_pkg::CFG_NODE_ADDRESS:    cfg_reg.node_address    <= cfg_data[7:0];
                rnarq_pkg::CFG_GATEWAY_ADDRESS: cfg_reg.gateway_address <= cfg_data[7:0];
                rnarq_pkg::CFG_WAKE_INTERVAL:   cfg_reg.wake_interval   <= cfg_data;
                rnarq_pkg::CFG_RETRY_LIMIT:     cfg_reg.retry_limit     <= cfg_data[7:0];
                rnarq_pkg::CFG_ACK_TIMEOUT_MS:  cfg_reg.ack_timeout_ms  <= cfg_data;
                rnarq_pkg::CFG_SLEEP_PERIOD:    cfg_reg.sleep_period    <= cfg_data;
                rnarq_pkg::CFG_POLLED_MODE:     cfg_reg.polled_mode     <= cfg_data[0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/rnarq_step.sv -----
// Next-state and result logic for one transaction of the radio link engine.
// Purely combinational; uses rnarq_pkg.
module rnarq_step (
    input  rnarq_pkg::rnarq_cfg_t   cfg,
    input  rnarq_pkg::rnarq_state_t st,
    input  rnarq_pkg::rnarq_in_t    item,
    output rnarq_pkg::rnarq_state_t st_next,
    output rnarq_pkg::rnarq_out_t   res
);

    // Enter sleep: LEDs off, reload the countdown unless already sleeping
    function automatic rnarq_pkg::rnarq_state_t go_sleep(
        input rnarq_pkg::rnarq_state_t s,
        input logic [15:0]             interval
    );
        rnarq_pkg::rnarq_state_t r;
        r = s;
        r.awake_led = 1'b0;
        r.test_led  = 1'b0;
        if (s.phase != rnarq_pkg::PH_SLEEP) begin
            r.wake_countdown = interval;
        end
        r.phase = rnarq_pkg::PH_SLEEP;
        return r;
    endfunction

    rnarq_pkg::rnarq_state_t ns;
    rnarq_pkg::rnarq_out_t   r;
    logic                    sleeper;
    logic                    done;
    logic                    addressed;

    always_comb begin
        ns        = st;
        r         = '0;
        sleeper   = !cfg.polled_mode;
        done      = 1'b0;
        addressed = item.rx_valid && (item.rx_dest == cfg.node_address);

        if (item.func) begin
            ns.phase            = rnarq_pkg::PH_SENDING;
            ns.attempts_left    = cfg.retry_limit;
            ns.outgoing_mid     = item.fresh_mid;
            ns.outgoing_ack_req = 1'b1;
        end else begin
            if (sleeper) begin
                ns.awake_led = 1'b1;
            end

            // Received frame handling
            if (addressed) begin
                r.deliver_rx = 1'b1;
                if (item.rx_ack_req) begin
                    if (sleeper) begin
                        ns.pending_ack_id = item.rx_mid;
                    end else begin
                        ns.phase            = rnarq_pkg::PH_SENDING;
                        ns.attempts_left    = cfg.retry_limit;
                        ns.outgoing_mid     = item.rx_mid;
                        ns.outgoing_ack_req = 1'b0;
                    end
                end else begin
                    if (sleeper) begin
                        ns.pending_ack_id = '0;
                    end
                    if (ns.phase == rnarq_pkg::PH_WAIT) begin
                        if (item.rx_admin) begin
                            ns.phase    = rnarq_pkg::PH_START;
                            ns.test_led = 1'b1;
                        end else if (item.rx_mid == ns.outgoing_mid) begin
                            if (sleeper) begin
                                ns          = go_sleep(ns, cfg.wake_interval);
                                r.sleep_for = cfg.sleep_period;
                            end else begin
                                ns.phase = rnarq_pkg::PH_LISTEN;
                            end
                        end
                    end
                end
            end

            // Startup: send the banner, then sleep or listen
            if (ns.phase == rnarq_pkg::PH_START) begin
                r.send_banner     = 1'b1;
                r.banner_ack_id   = ns.pending_ack_id;
                ns.pending_ack_id = '0;
                if (sleeper) begin
                    ns.test_led = 1'b0;
                    ns          = go_sleep(ns, cfg.wake_interval);
                    r.sleep_for = cfg.sleep_period;
                end else begin
                    ns.phase = rnarq_pkg::PH_LISTEN;
                end
                done = 1'b1;
            end

            // Sleep period elapsed: count down, wake when it runs out
            if (!done && sleeper && ns.phase == rnarq_pkg::PH_SLEEP) begin
                done = 1'b1;
                if (ns.wake_countdown != '0 && ns.wake_countdown != 16'd1) begin
                    ns.wake_countdown = ns.wake_countdown - 16'd1;
                    ns                = go_sleep(ns, cfg.wake_interval);
                    r.sleep_for       = cfg.sleep_period;
                end else begin
                    ns.wake_countdown   = '0;
                    ns.phase            = rnarq_pkg::PH_SENDING;
                    ns.attempts_left    = cfg.retry_limit;
                    ns.outgoing_mid     = item.fresh_mid;
                    ns.outgoing_ack_req = 1'b1;
                    r.radio_wake        = 1'b1;
                end
            end

            if (!done && ns.phase == rnarq_pkg::PH_SENDING) begin
                done = 1'b1;
                if (item.link_free) begin
                    r.send_data     = 1'b1;
                    r.data_mid      = ns.outgoing_mid;
                    r.data_ack_req  = ns.outgoing_ack_req;
                    ns.phase        = rnarq_pkg::PH_WAIT;
                    ns.ack_deadline = item.now_ms + {16'd0, cfg.ack_timeout_ms};
                end
            end

            // Ack timeout: retry or give up
            if (!done && ns.phase == rnarq_pkg::PH_WAIT) begin
                if (item.now_ms > ns.ack_deadline) begin
                    if (ns.attempts_left > 8'd1) begin
                        ns.attempts_left = ns.attempts_left - 8'd1;
                        ns.phase         = rnarq_pkg::PH_SENDING;
                    end else begin
                        ns.attempts_left = '0;
                        if (sleeper) begin
                            ns          = go_sleep(ns, cfg.wake_interval);
                            r.sleep_for = cfg.sleep_period;
                        end
                    end
                end
            end
        end

        r.led_awake  = ns.awake_led;
        r.led_test   = ns.test_led;
        r.link_state = ns.phase;
    end

    assign st_next = ns;
    assign res     = r;

endmodule

// ----- hw/rtl/radio_node_ack_retry_engine_unit.sv -----
// Top level of the stop-and-wait radio link engine: input register, step logic,
// result register and protocol state. Uses rnarq_pkg, rnarq_cfg_regs, rnarq_step.
//
// Every input transaction (a poll step or a transmit request) yields exactly one
// result transaction. The engine takes one transaction per clock unless the
// result channel stalls: it is captured in an input register, evaluated against
// the protocol state by one pass of compare and add logic (the 32-bit deadline
// add and compare set the path), and the result moves into an output register
// once that register is free, while the state updates in the same edge, so the
// next transaction sees it. A stalled result register holds the input register,
// and s_ready drops only when both are full. Configuration writes are always
// accepted (cfg_ready is tied high) and take effect on the next edge; write them
// only while no transaction is in flight.
module radio_node_ack_retry_engine_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rnarq_pkg::rnarq_in_t          s_data,
    // result transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output rnarq_pkg::rnarq_out_t         m_data,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rnarq_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rnarq_pkg::CfgDataW-1:0] cfg_data
);

    rnarq_pkg::rnarq_cfg_t   cfg;
    rnarq_pkg::rnarq_state_t state_reg;
    rnarq_pkg::rnarq_state_t state_next;
    rnarq_pkg::rnarq_in_t    stage_item_reg;
    logic                    stage_valid_reg;
    rnarq_pkg::rnarq_out_t   out_item_reg;
    rnarq_pkg::rnarq_out_t   out_item_next;
    logic                    out_valid_reg;
    logic                    advance;

    assign cfg_ready = 1'b1;

    rnarq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rnarq_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (stage_item_reg),
        .st_next (state_next),
        .res     (out_item_next)
    );

    // Move the staged transaction into the result register when that slot frees
    assign advance = stage_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;

    // Control: valid flags and protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{phase: rnarq_pkg::PH_START, default: '0};
        end else begin
            if (s_valid && s_ready) begin
                stage_valid_reg <= 1'b1;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture on acceptance, hold while stalled
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // An accepted transaction is always staged on the next edge
    a_accept_staged: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> stage_valid_reg)
        else $error("accepted transaction not staged");

    // A data send always leaves the engine waiting for the ack
    a_send_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.send_data |-> m_data.link_state == rnarq_pkg::PH_WAIT)
        else $error("data sent without entering ack wait");

    // The banner leads straight to sleep or listen
    a_banner_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.send_banner |->
            (m_data.link_state == rnarq_pkg::PH_SLEEP ||
             m_data.link_state == rnarq_pkg::PH_LISTEN))
        else $error("banner sent from unexpected phase");

    // A transmit request always lands the engine in sending
    a_request_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stage_item_reg.func |=> state_reg.phase == rnarq_pkg::PH_SENDING)
        else $error("transmit request did not start sending");

endmodule

// ----- bench/tb_radio_node_ack_retry_engine_unit.sv -----
// Self-checking testbench for radio_node_ack_retry_engine_unit.
// Holds a cycle-free link-engine predictor, a queue-fed driver and a checking monitor.
// Depends on rnarq_pkg and the engine top level only.
`timescale 1ns / 100ps

module tb_radio_node_ack_retry_engine_unit;

    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transaction at all
    localparam int unsigned MAX_REPORTS = 40;    // cap on printed mismatch lines
    localparam int unsigned SETTLE_CYCLES = 20;  // pipeline is two deep, leave margin

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rnarq_pkg::rnarq_in_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rnarq_pkg::rnarq_out_t m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rnarq_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [rnarq_pkg::CfgDataW-1:0] cfg_data  = '0;

    radio_node_ack_retry_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: register copies and protocol state of the engine
    // ------------------------------------------------------------------
    logic [7:0]  reg_node_address = rnarq_pkg::RST_NODE_ADDRESS;
    logic [15:0] reg_wake_interval = rnarq_pkg::RST_WAKE_INTERVAL;
    logic [7:0]  reg_retry_limit = rnarq_pkg::RST_RETRY_LIMIT;
    logic [15:0] reg_ack_timeout = rnarq_pkg::RST_ACK_TIMEOUT_MS;
    logic [15:0] reg_sleep_period = rnarq_pkg::RST_SLEEP_PERIOD;
    logic        reg_polled = rnarq_pkg::RST_POLLED_MODE;

    rnarq_pkg::rnarq_phase_t lk_phase = rnarq_pkg::PH_START;
    logic [15:0]  wake_count = '0;
    logic [7:0]   tries_left = '0;
    logic [31:0]  ack_due = '0;
    logic [7:0]   banner_ack_pending = '0;
    logic [7:0]   tx_mid = '0;
    logic         tx_ack_req = 1'b0;
    logic         awake_lvl = 1'b0;
    logic         test_lvl = 1'b0;
    logic [15:0]  sleep_req = '0;

    // Drop into sleep; reload the countdown only when coming from another phase.
    function automatic void enter_sleep();
        awake_lvl = 1'b0;
        test_lvl  = 1'b0;
        if (lk_phase != rnarq_pkg::PH_SLEEP)
            wake_count = reg_wake_interval;
        lk_phase  = rnarq_pkg::PH_SLEEP;
        sleep_req = reg_sleep_period;
    endfunction

    function automatic void begin_tx(logic [7:0] mid, logic ackreq);
        lk_phase   = rnarq_pkg::PH_SENDING;
        tries_left = reg_retry_limit;
        tx_mid     = mid;
        tx_ack_req = ackreq;
    endfunction

    // Advance the engine state by one transaction and build its result.
    function automatic rnarq_pkg::rnarq_out_t predict_link_step(rnarq_pkg::rnarq_in_t it);
        rnarq_pkg::rnarq_out_t r;
        logic       sleeper;
        logic       done;
        logic       hold;
        r         = '0;
        sleep_req = '0;
        if (it.func) begin
            begin_tx(it.fresh_mid, 1'b1);
        end else begin
            sleeper = !reg_polled;
            done    = 1'b0;
            hold    = 1'b0;
            if (sleeper)
                awake_lvl = 1'b1;
            if (it.rx_valid && it.rx_dest == reg_node_address) begin
                r.deliver_rx = 1'b1;
                if (it.rx_ack_req) begin
                    if (sleeper)
                        banner_ack_pending = it.rx_mid;
                    else
                        begin_tx(it.rx_mid, 1'b0);
                end else begin
                    if (sleeper)
                        banner_ack_pending = '0;
                    if (lk_phase == rnarq_pkg::PH_WAIT) begin
                        if (it.rx_admin) begin
                            lk_phase = rnarq_pkg::PH_START;
                            test_lvl = 1'b1;
                        end else if (it.rx_mid == tx_mid) begin
                            if (sleeper)
                                enter_sleep();
                            else
                                lk_phase = rnarq_pkg::PH_LISTEN;
                        end
                    end
                end
            end

            if (lk_phase == rnarq_pkg::PH_START) begin
                r.send_banner      = 1'b1;
                r.banner_ack_id    = banner_ack_pending;
                banner_ack_pending = '0;
                if (sleeper) begin
                    test_lvl = 1'b0;
                    enter_sleep();
                end else begin
                    lk_phase = rnarq_pkg::PH_LISTEN;
                end
                done = 1'b1;
            end

            // Sleep phase: count down, and wake for a fresh data message at zero
            if (!done && sleeper && lk_phase == rnarq_pkg::PH_SLEEP) begin
                done = 1'b1;
                if (wake_count != 16'd0) begin
                    wake_count = wake_count - 16'd1;
                    if (wake_count != 16'd0) begin
                        enter_sleep();
                        hold = 1'b1;
                    end
                end
                if (!hold) begin
                    begin_tx(it.fresh_mid, 1'b1);
                    r.radio_wake = 1'b1;
                end
            end

            if (!done && lk_phase == rnarq_pkg::PH_SENDING) begin
                done = 1'b1;
                if (it.link_free) begin
                    r.send_data    = 1'b1;
                    r.data_mid     = tx_mid;
                    r.data_ack_req = tx_ack_req;
                    lk_phase       = rnarq_pkg::PH_WAIT;
                    ack_due        = it.now_ms + {16'd0, reg_ack_timeout};
                end
            end

            // Ack wait: on timeout retry, or give up once the attempts are gone
            if (!done && lk_phase == rnarq_pkg::PH_WAIT) begin
                if (it.now_ms > ack_due) begin
                    if (tries_left > 8'd1) begin
                        tries_left = tries_left - 8'd1;
                        lk_phase   = rnarq_pkg::PH_SENDING;
                    end else begin
                        tries_left = '0;
                        if (sleeper)
                            enter_sleep();
                    end
                end
            end
        end
        r.sleep_for  = sleep_req;
        r.led_awake  = awake_lvl;
        r.led_test   = test_lvl;
        r.link_state = lk_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed pending steps onto the input channel
    // ------------------------------------------------------------------
    rnarq_pkg::rnarq_in_t  pending_steps[$];
    rnarq_pkg::rnarq_out_t expected_results[$];
    int unsigned errors = 0;
    int unsigned send_gap = 0;
    bit          send_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_link_step(s_data));
                send_gap = send_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    send_steady = !send_steady;
            end
            // Hold the payload while a transaction waits; otherwise idle or load the next
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_steps.size() != 0) begin
                    s_data  <= pending_steps.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result channel at random and check every result
    // ------------------------------------------------------------------
    int unsigned recv_stall = 0;
    bit          recv_steady = 1'b0;

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    task automatic compare_result(rnarq_pkg::rnarq_out_t want, rnarq_pkg::rnarq_out_t got);
        report_field("send_banner", 32'(want.send_banner), 32'(got.send_banner));
        report_field("banner_ack_id", 32'(want.banner_ack_id), 32'(got.banner_ack_id));
        report_field("send_data", 32'(want.send_data), 32'(got.send_data));
        report_field("data_mid", 32'(want.data_mid), 32'(got.data_mid));
        report_field("data_ack_req", 32'(want.data_ack_req), 32'(got.data_ack_req));
        report_field("sleep_for", 32'(want.sleep_for), 32'(got.sleep_for));
        report_field("radio_wake", 32'(want.radio_wake), 32'(got.radio_wake));
        report_field("led_awake", 32'(want.led_awake), 32'(got.led_awake));
        report_field("led_test", 32'(want.led_test), 32'(got.led_test));
        report_field("deliver_rx", 32'(want.deliver_rx), 32'(got.deliver_rx));
        report_field("link_state", 32'(want.link_state), 32'(got.link_state));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual 0x%0h",
                                 $time, m_data);
                end else begin
                    compare_result(expected_results.pop_front(), m_data);
                end
                recv_stall = recv_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    recv_steady = !recv_steady;
            end
            if (recv_stall != 0) begin
                recv_stall = recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] gen_clock = '0;  // millisecond time base of the random steps
    logic [7:0]  gen_mid = '0;    // message id reused for a while so acks can match

    task automatic write_reg(logic [rnarq_pkg::CfgIdxW-1:0] idx,
                             logic [rnarq_pkg::CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            rnarq_pkg::CFG_NODE_ADDRESS:   reg_node_address = data[7:0];
            rnarq_pkg::CFG_WAKE_INTERVAL:  reg_wake_interval = data;
            rnarq_pkg::CFG_RETRY_LIMIT:    reg_retry_limit = data[7:0];
            rnarq_pkg::CFG_ACK_TIMEOUT_MS: reg_ack_timeout = data;
            rnarq_pkg::CFG_SLEEP_PERIOD:   reg_sleep_period = data;
            rnarq_pkg::CFG_POLLED_MODE:    reg_polled = data[0];
            default: ;  // gateway address never shows in a result
        endcase
    endtask

    task automatic apply_config(logic [7:0] node, logic [7:0] gw, logic [15:0] wake,
                                logic [7:0] retry, logic [15:0] timeout,
                                logic [15:0] sleep_len, logic polled);
        write_reg(rnarq_pkg::CFG_NODE_ADDRESS, {8'd0, node});
        write_reg(rnarq_pkg::CFG_GATEWAY_ADDRESS, {8'd0, gw});
        write_reg(rnarq_pkg::CFG_WAKE_INTERVAL, wake);
        write_reg(rnarq_pkg::CFG_RETRY_LIMIT, {8'd0, retry});
        write_reg(rnarq_pkg::CFG_ACK_TIMEOUT_MS, timeout);
        write_reg(rnarq_pkg::CFG_SLEEP_PERIOD, sleep_len);
        write_reg(rnarq_pkg::CFG_POLLED_MODE, {15'd0, polled});
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every queued step went in and every result came back,
    // then let the clock run on before touching registers.
    task automatic wait_drained();
        while (pending_steps.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic rnarq_pkg::rnarq_in_t poll_step(int unsigned rxv, logic [7:0] dest,
                                                       int unsigned ackreq,
                                                       int unsigned admin, logic [7:0] mid,
                                                       int unsigned free,
                                                       logic [31:0] now, logic [7:0] fresh);
        rnarq_pkg::rnarq_in_t it;
        it            = '0;
        it.rx_valid   = 1'(rxv);
        it.rx_dest    = dest;
        it.rx_ack_req = 1'(ackreq);
        it.rx_admin   = 1'(admin);
        it.rx_mid     = mid;
        it.link_free  = 1'(free);
        it.now_ms     = now;
        it.fresh_mid  = fresh;
        return it;
    endfunction

    function automatic rnarq_pkg::rnarq_in_t tx_request(logic [7:0] fresh);
        rnarq_pkg::rnarq_in_t it;
        it           = '0;
        it.func      = 1'b1;
        it.fresh_mid = fresh;
        return it;
    endfunction

    // Mostly well-formed traffic: frames for this node, acks carrying the id in
    // flight, time stepping near the deadline; the rest is noise.
    function automatic rnarq_pkg::rnarq_in_t random_step();
        rnarq_pkg::rnarq_in_t it;
        logic [63:0] raw;
        int unsigned pick;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(0, 15) == 0)
            return raw[$bits(rnarq_pkg::rnarq_in_t)-1:0];
        pick = $urandom_range(0, 9);
        if (pick < 5)
            gen_clock = gen_clock + $urandom_range(0, reg_ack_timeout / 2 + 1);
        else if (pick < 9)
            gen_clock = gen_clock + reg_ack_timeout + $urandom_range(0, 2);
        else
            gen_clock = $urandom();
        if ($urandom_range(0, 7) == 0)
            gen_mid = 8'($urandom_range(0, 255));
        it            = '0;
        it.func       = ($urandom_range(0, 15) == 0);
        it.rx_valid   = ($urandom_range(0, 9) < 4);
        it.rx_dest    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : reg_node_address;
        it.rx_ack_req = ($urandom_range(0, 3) == 0);
        it.rx_admin   = ($urandom_range(0, 15) == 0);
        it.rx_mid     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : gen_mid;
        it.link_free  = ($urandom_range(0, 9) < 7);
        it.now_ms     = gen_clock;
        it.fresh_mid  = gen_mid;
        return it;
    endfunction

    task automatic run_random(int unsigned count);
        repeat (count) pending_steps.push_back(random_step());
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, sleeper with reset registers (node 1, wake 1, three tries,
        // 100 ms timeout)
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'd0, 8'h11));  // banner
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'd5, 8'h22));  // wake
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'd6, 8'h00));  // busy
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd1000, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'd1100, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'd1101, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd1101, 8'h00));
        // frame for another node, then the matching ack: sleep and wake in one step
        pending_steps.push_back(poll_step(1, 8'h02, 0, 0, 8'h22, 0, 32'd1102, 8'h00));
        pending_steps.push_back(poll_step(1, 8'h01, 0, 0, 8'h22, 0, 32'd1103, 8'h33));
        // deadline wraps past 2^32
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'hFFFF_FFF0, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'hFFFF_FFF1, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'hFFFF_FFFF, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'hFFFF_FFFF, 8'h00));
        // last attempt times out: give up and sleep
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'hFFFF_FFFF, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 0, 32'h0000_0064, 8'h00));
        pending_steps.push_back(poll_step(1, 8'h01, 1, 0, 8'hAB, 0, 32'd200, 8'h44));
        pending_steps.push_back('1);  // transmit request with every field at its maximum
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd500, 8'h00));
        // admin frame during the ack wait forces a restart
        pending_steps.push_back(poll_step(1, 8'h01, 0, 1, 8'h7E, 0, 32'd501, 8'h00));
        wait_drained();

        // Directed, polled listener: retries run out and it keeps waiting
        apply_config(8'h01, 8'h00, 16'd1, 8'd1, 16'd1, 16'd1000, 1'b1);
        pending_steps.push_back(tx_request(8'h44));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd10, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd12, 8'h00));
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd40, 8'h00));
        pending_steps.push_back(poll_step(1, 8'h01, 0, 0, 8'h44, 0, 32'd41, 8'h00));
        pending_steps.push_back(poll_step(1, 8'h01, 1, 0, 8'h55, 1, 32'd42, 8'h00));
        pending_steps.push_back(poll_step(1, 8'h01, 0, 0, 8'h55, 0, 32'd43, 8'h00));
        wait_drained();

        // Back to sleeper while listening: the listen phase does nothing here
        apply_config(8'h01, 8'h00, 16'd1, 8'd3, 16'd100, 16'd1000, 1'b0);
        pending_steps.push_back(poll_step(0, 8'h00, 0, 0, 8'h00, 1, 32'd44, 8'h00));
        wait_drained();

        // Random phases; each boundary holds the sender until all results are in
        apply_config(8'h00, 8'hFF, 16'd0, 8'd1, 16'd1, 16'd0, 1'b0);
        run_random(120);
        apply_config(8'hFF, 8'h00, 16'd2, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(120);
        apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(1, 4)), 8'($urandom_range(2, 5)),
                     16'($urandom_range(1, 50)), 16'($urandom_range(0, 65535)), 1'b0);
        run_random(180);
        apply_config(8'h5A, 8'hA5, 16'd3, 8'd0, 16'd3, 16'h5555, 1'b1);
        run_random(120);
        apply_config(8'h01, 8'h00, 16'hFFFF, 8'd255, 16'd1, 16'hAAAA, 1'b0);
        run_random(40);
        repeat (4) begin
            apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 3)), 8'($urandom_range(0, 6)),
                         16'($urandom_range(1, 200)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
            run_random(55);
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_results.size());
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
